FILE: rtl/bta_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bakery ticket arbiter package
// Shared sizes, operation codes and the structs that link the arbiter parts.
// ----------------------------------------------------------------------------
package bta_pkg;

   localparam int REQUESTERS  = 8;
   localparam int TICKET_BITS = 16;
   localparam int IDX_W       = (REQUESTERS > 1) ? $clog2(REQUESTERS) : 1;
   localparam int KIND_W      = 2;
   localparam int WHO_W       = 3;
   localparam int HELD_W      = 16;

   typedef enum logic [KIND_W-1:0] {
      KIND_TAKE    = 2'd0,
      KIND_POLL    = 2'd1,
      KIND_RELEASE = 2'd2,
      KIND_SPARE   = 2'd3
   } kind_type;

   typedef logic [TICKET_BITS-1:0] ticket_type;
   typedef logic [IDX_W-1:0]       idx_type;

   typedef struct packed {
      logic    en;
      idx_type addr;
   } store_rd_type;

   typedef struct packed {
      logic       en;
      idx_type    addr;
      ticket_type data;
   } store_wr_type;

   typedef struct packed {
      logic lt;
      logic eq;
      logic zero;
   } cmp_res_type;

endpackage
`default_nettype wire

FILE: rtl/bta_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bakery ticket store
// One ticket per requester with a registered read port and one write port.
// Entries read as zero until written after reset.
// ----------------------------------------------------------------------------
module bta_store
   import bta_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire store_rd_type rd,
   input  wire store_wr_type wr,
   output ticket_type        rd_data
);

   ticket_type                  mem [REQUESTERS];
   logic       [REQUESTERS-1:0] vld_ff;
   ticket_type                  rd_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (wr.en) begin
         vld_ff[wr.addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd.en) begin
         rd_data_ff <= vld_ff[rd.addr] ? mem[rd.addr] : '0;
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

FILE: rtl/bta_cmp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bakery ticket comparator
// The shared ticket compare unit used at every step of the store walk.
// ----------------------------------------------------------------------------
module bta_cmp
   import bta_pkg::*;
(
   input  wire ticket_type  a,
   input  wire ticket_type  b,
   output cmp_res_type      res
);

   always_comb begin
      res.lt   = (a < b);
      res.eq   = (a == b);
      res.zero = (a == '0);
   end

endmodule
`default_nettype wire

FILE: rtl/bakery_ticket_arbiter_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bakery ticket arbiter
// Keeps one ticket per requester and answers take, poll and release items.
//
// The req_ channel carries one operation per item: the kind in req_tuser and
// the requester number in req_tdata. The rsp_ channel returns one item per
// request with the requester's ticket, the grant flag and the overflow flag.
// The block works on one item at a time. After an item is taken it reads the
// requester's own ticket and then walks all REQUESTERS ticket entries through
// one comparator, one entry per cycle, and for a take or a release writes the
// requester's ticket back. A take refused on overflow walks the entries a
// second time. A requester number outside the table answers zeros in the next
// cycle. req_tready is high only while the block is idle. The result is held
// in an output register until rsp_tready takes it; while the receiver stalls
// no new item is accepted. Reset clears all tickets to zero at once and leaves
// the block idle with no result pending.
// ----------------------------------------------------------------------------
module bakery_ticket_arbiter_unit
   import bta_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [2:0] requester
   input  wire logic [1:0]  req_tuser,   // [1:0] kind
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata    // [15:0] ticket_held, [16] granted,
                                         // [17] overflow
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_DECIDE,
      S_RESULT
   } state_type;

   state_type             state_ff,     state_in;
   kind_type              kind_ff,      kind_in;
   logic [WHO_W-1:0]      who_ff,       who_in;
   idx_type               idx_ff,       idx_in;
   logic                  issue_ff,     issue_in;
   logic                  eval_vld_ff,  eval_vld_in;
   idx_type               eval_idx_ff,  eval_idx_in;
   logic                  mine_pend_ff, mine_pend_in;
   logic                  take_pass_ff, take_pass_in;
   ticket_type            mine_ff,      mine_in;
   ticket_type            max_ff,       max_in;
   logic                  others_ff,    others_in;
   logic                  beaten_ff,    beaten_in;
   logic                  ovf_ff,       ovf_in;
   logic [HELD_W-1:0]     held_ff,      held_in;
   logic                  grant_ff,     grant_in;
   logic                  rsp_ovf_ff,   rsp_ovf_in;
   logic                  rsp_vld_ff,   rsp_vld_in;

   store_rd_type          rd;
   store_wr_type          wr;
   ticket_type            rd_data;
   ticket_type            cmp_b;
   cmp_res_type           cmp;
   ticket_type            next_ticket;
   logic [WHO_W-1:0]      req_who;
   logic                  req_in_range;
   logic                  is_other;
   logic                  is_lower;

   localparam idx_type LAST_IDX = IDX_W'(REQUESTERS - 1);

   bta_store u_store (
      .clock   (clock),
      .reset   (reset),
      .rd      (rd),
      .wr      (wr),
      .rd_data (rd_data)
   );

   assign cmp_b = take_pass_ff ? max_ff : mine_ff;

   bta_cmp u_cmp (
      .a   (rd_data),
      .b   (cmp_b),
      .res (cmp)
   );

   assign req_who      = req_tdata[WHO_W-1:0];
   assign req_in_range = (32'(req_who) < REQUESTERS);
   assign is_other     = (32'(eval_idx_ff) != 32'(who_ff));
   assign is_lower     = (32'(eval_idx_ff) < 32'(who_ff));
   assign next_ticket  = max_ff + TICKET_BITS'(1);

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      who_in       = who_ff;
      idx_in       = idx_ff;
      issue_in     = issue_ff;
      eval_vld_in  = 1'b0;
      eval_idx_in  = eval_idx_ff;
      mine_pend_in = mine_pend_ff;
      take_pass_in = take_pass_ff;
      mine_in      = mine_ff;
      max_in       = max_ff;
      others_in    = others_ff;
      beaten_in    = beaten_ff;
      ovf_in       = ovf_ff;
      held_in      = held_ff;
      grant_in     = grant_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      rsp_vld_in   = rsp_vld_ff;
      rd.en        = 1'b0;
      rd.addr      = idx_ff;
      wr.en        = 1'b0;
      wr.addr      = IDX_W'(who_ff);
      wr.data      = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               kind_in = kind_type'(req_tuser);
               who_in  = req_who;
               if (req_in_range) begin
                  rd.en        = 1'b1;
                  rd.addr      = IDX_W'(req_who);
                  mine_pend_in = 1'b1;
                  issue_in     = 1'b1;
                  idx_in       = '0;
                  take_pass_in = (kind_type'(req_tuser) == KIND_TAKE);
                  max_in       = '0;
                  others_in    = 1'b0;
                  beaten_in    = 1'b0;
                  ovf_in       = 1'b0;
                  state_in     = S_SCAN;
               end else begin
                  held_in    = '0;
                  grant_in   = 1'b0;
                  rsp_ovf_in = 1'b0;
                  rsp_vld_in = 1'b1;
                  state_in   = S_RESULT;
               end
            end
         end
         S_SCAN: begin
            eval_vld_in = issue_ff;
            eval_idx_in = idx_ff;
            if (issue_ff) begin
               rd.en   = 1'b1;
               rd.addr = idx_ff;
               if (idx_ff == LAST_IDX) begin
                  issue_in = 1'b0;
               end else begin
                  idx_in = idx_ff + IDX_W'(1);
               end
            end
            if (mine_pend_ff) begin
               mine_in      = rd_data;
               mine_pend_in = 1'b0;
            end else if (eval_vld_ff) begin
               if (take_pass_ff) begin
                  if (!cmp.lt && !cmp.eq) begin
                     max_in = rd_data;
                  end
                  if (is_other && !cmp.zero) begin
                     others_in = 1'b1;
                  end
               end else if (is_other && !cmp.zero && (cmp.lt || (cmp.eq && is_lower))) begin
                  beaten_in = 1'b1;
               end
            end
            if (!issue_ff && !eval_vld_ff && !mine_pend_ff) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (take_pass_ff) begin
               if (max_ff == '1) begin
                  ovf_in       = 1'b1;
                  take_pass_in = 1'b0;
                  issue_in     = 1'b1;
                  idx_in       = '0;
                  beaten_in    = 1'b0;
                  state_in     = S_SCAN;
               end else begin
                  wr.en      = 1'b1;
                  wr.data    = next_ticket;
                  held_in    = HELD_W'(next_ticket);
                  grant_in   = !others_ff;
                  rsp_ovf_in = 1'b0;
                  rsp_vld_in = 1'b1;
                  state_in   = S_RESULT;
               end
            end else if (kind_ff == KIND_RELEASE) begin
               wr.en      = 1'b1;
               wr.data    = '0;
               held_in    = '0;
               grant_in   = 1'b0;
               rsp_ovf_in = 1'b0;
               rsp_vld_in = 1'b1;
               state_in   = S_RESULT;
            end else begin
               held_in    = HELD_W'(mine_ff);
               grant_in   = (mine_ff != '0) && !beaten_ff;
               rsp_ovf_in = ovf_ff;
               rsp_vld_in = 1'b1;
               state_in   = S_RESULT;
            end
         end
         S_RESULT: begin
            if (rsp_tready) begin
               rsp_vld_in = 1'b0;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in   = S_IDLE;
            rsp_vld_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         issue_ff     <= 1'b0;
         eval_vld_ff  <= 1'b0;
         mine_pend_ff <= 1'b0;
         rsp_vld_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         issue_ff     <= issue_in;
         eval_vld_ff  <= eval_vld_in;
         mine_pend_ff <= mine_pend_in;
         rsp_vld_ff   <= rsp_vld_in;
      end
      kind_ff      <= kind_in;
      who_ff       <= who_in;
      idx_ff       <= idx_in;
      eval_idx_ff  <= eval_idx_in;
      take_pass_ff <= take_pass_in;
      mine_ff      <= mine_in;
      max_ff       <= max_in;
      others_ff    <= others_in;
      beaten_ff    <= beaten_in;
      ovf_ff       <= ovf_in;
      held_ff      <= held_in;
      grant_ff     <= grant_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {6'b0, rsp_ovf_ff, grant_ff, held_ff};

   // A result is never offered while a new item can be taken.
   a_one_item : assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("result pending while idle");

   // The store is written only when an item is being finished.
   a_write_decide : assert property (@(posedge clock) disable iff (reset)
      wr.en |-> (state_ff == S_DECIDE))
      else $error("store write outside decide");

   // A granted requester always holds a ticket.
   a_grant_ticket : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && grant_ff) |-> (held_ff != '0))
      else $error("grant without ticket");

   // Overflow is reported only for a take.
   a_ovf_take : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_ovf_ff) |-> (kind_ff == KIND_TAKE))
      else $error("overflow on non-take item");

   // A refused take leaves the store untouched.
   a_ovf_no_write : assert property (@(posedge clock) disable iff (reset)
      (wr.en && ovf_ff) |-> 1'b0)
      else $error("write after overflow");

endmodule
`default_nettype wire
